/* rtl/ubr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubr_pkg: shared definitions for the unbalanced bracket reporter
// Widths, token codes, stack indexes and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ubr_pkg;

  // Document size and the widths that follow from it.
  localparam int DOC_LINES = 1024;
  localparam int POS_W     = $clog2(DOC_LINES);
  localparam int TOP_W     = $clog2(DOC_LINES + 1);

  // Fixed field widths.
  localparam int KIND_W = 3;
  localparam int LINE_W = 10;
  localparam int REP_W  = 6;

  localparam logic [REP_W-1:0] MAX_REPORTS_RST = 6'd63;

  // Token kind codes.
  localparam logic [KIND_W-1:0] KIND_OTHER       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_MATRIX = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_MATRIX  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BEGIN       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END         = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PUSH_ATTRIB = 3'd5;
  localparam logic [KIND_W-1:0] KIND_POP_ATTRIB  = 3'd6;

  // Stack indexes, in flush order.
  localparam int NUM_STACKS = 3;
  localparam logic [1:0] STK_MATRIX = 2'd0;
  localparam logic [1:0] STK_BEGIN  = 2'd1;
  localparam logic [1:0] STK_ATTRIB = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       flush_rd;
    logic       flush_emit;
    logic       next_stack;
    logic       summary;
    logic [1:0] stack_sel;
  } ubr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic stack_done;
    logic cap_hit;
  } ubr_sts_t;

endpackage

/* rtl/ubr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubr_if: request channels of the unbalanced bracket reporter
// Token channel into the block and result channel out of it, each with
// valid, ready and the payload.
// ----------------------------------------------------------------------------
interface ubr_tok_if;
  import ubr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic              token_valid;
  logic              last_token;

  modport source (output valid, token_kind, token_valid, last_token, input ready);
  modport sink   (input valid, token_kind, token_valid, last_token, output ready);
endinterface

interface ubr_res_if;
  import ubr_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_index;
  logic              is_report;
  logic [REP_W-1:0]  report_total;
  logic              end_of_run;

  modport source (output valid, line_index, is_report, report_total, end_of_run,
                  input ready);
  modport sink   (input valid, line_index, is_report, report_total, end_of_run,
                  output ready);
endinterface

/* rtl/ubr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Read data holds until the
// next read.
// ----------------------------------------------------------------------------
module ubr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ubr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubr_dp: datapath of the unbalanced bracket reporter
// Holds the three opener stacks, their tops, the position and report
// counters, the report cap and the result register.
// ----------------------------------------------------------------------------
module ubr_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ubr_pkg::ubr_cmd_t          cmd,
  output ubr_pkg::ubr_sts_t          sts,
  input  logic [ubr_pkg::KIND_W-1:0] in_kind,
  input  logic                       in_tvalid,
  input  logic                       in_last,
  input  logic                       cfg_we,
  input  logic [ubr_pkg::REP_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ubr_pkg::LINE_W-1:0] out_line,
  output logic                       out_is_report,
  output logic [ubr_pkg::REP_W-1:0]  out_total,
  output logic                       out_eor
);
  import ubr_pkg::*;

  logic [REP_W-1:0]  max_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [TOP_W-1:0]  top_r [NUM_STACKS];
  logic [TOP_W-1:0]  top_nxt [NUM_STACKS];
  logic [TOP_W-1:0]  k_r, k_nxt;

  logic              out_valid_r;
  logic [LINE_W-1:0] line_r;
  logic              is_rep_r;
  logic [REP_W-1:0]  total_r;
  logic              eor_r;

  logic              load;
  logic [LINE_W-1:0] ld_line;
  logic              ld_is_rep;
  logic [REP_W-1:0]  ld_total;
  logic              ld_eor;

  logic              tok_push, tok_pop;
  logic [1:0]        tok_stk;
  logic [TOP_W-1:0]  tok_top, sel_top;
  logic [POS_W-1:0]  sel_data;
  logic              cap_hit, out_free;

  logic [NUM_STACKS-1:0] wr_en, rd_en;
  logic [POS_W-1:0]      rd_data [NUM_STACKS];

  // Token decode: which stack, push or pop.
  always_comb begin
    tok_push = 1'b0;
    tok_pop  = 1'b0;
    tok_stk  = STK_MATRIX;
    case (in_kind)
      KIND_PUSH_MATRIX: begin tok_push = in_tvalid; tok_stk = STK_MATRIX; end
      KIND_POP_MATRIX:  begin tok_pop  = in_tvalid; tok_stk = STK_MATRIX; end
      KIND_BEGIN:       begin tok_push = in_tvalid; tok_stk = STK_BEGIN;  end
      KIND_END:         begin tok_pop  = in_tvalid; tok_stk = STK_BEGIN;  end
      KIND_PUSH_ATTRIB: begin tok_push = in_tvalid; tok_stk = STK_ATTRIB; end
      KIND_POP_ATTRIB:  begin tok_pop  = in_tvalid; tok_stk = STK_ATTRIB; end
      default: begin end
    endcase
  end

  // Top of the token's stack, and top and read data of the flushed stack.
  always_comb begin
    tok_top  = '0;
    sel_top  = '0;
    sel_data = '0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (tok_stk == 2'(s)) begin
        tok_top = top_r[s];
      end
      if (cmd.stack_sel == 2'(s)) begin
        sel_top  = top_r[s];
        sel_data = rd_data[s];
      end
    end
  end

  assign cap_hit        = (rep_r >= max_r);
  assign out_free       = !out_valid_r || out_ready;
  assign sts.out_free   = out_free;
  assign sts.cap_hit    = cap_hit;
  assign sts.stack_done = (k_r == sel_top);

  // Next-state logic for counters, tops and the result register load.
  always_comb begin
    pos_nxt   = pos_r;
    rep_nxt   = rep_r;
    k_nxt     = k_r;
    top_nxt   = top_r;
    wr_en     = '0;
    rd_en     = '0;
    load      = 1'b0;
    ld_line   = '0;
    ld_is_rep = 1'b0;
    ld_total  = '0;
    ld_eor    = 1'b0;

    if (cmd.accept) begin
      k_nxt = '0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        if (tok_stk == 2'(s)) begin
          if (tok_push && tok_top != TOP_W'(DOC_LINES)) begin
            top_nxt[s] = tok_top + 1'b1;
            wr_en[s]   = 1'b1;
          end
          if (tok_pop && tok_top != '0) begin
            top_nxt[s] = tok_top - 1'b1;
          end
        end
      end
      // A closer that meets an empty stack is an orphan.
      if (tok_pop && tok_top == '0 && !cap_hit) begin
        load      = 1'b1;
        ld_line   = LINE_W'(pos_r);
        ld_is_rep = 1'b1;
        ld_eor    = !in_last;
        rep_nxt   = rep_r + 1'b1;
      end
      if (in_last || pos_r == POS_W'(DOC_LINES - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end

    // Flush: read the entry at the walk index, then report it.
    if (cmd.flush_rd) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        if (cmd.stack_sel == 2'(s)) begin
          rd_en[s] = 1'b1;
        end
      end
    end
    if (cmd.flush_emit) begin
      load      = 1'b1;
      ld_line   = LINE_W'(sel_data);
      ld_is_rep = 1'b1;
      rep_nxt   = rep_r + 1'b1;
      k_nxt     = k_r + 1'b1;
    end
    if (cmd.next_stack) begin
      k_nxt = '0;
    end

    // Summary item closes the scan and clears the scan state.
    if (cmd.summary) begin
      load     = 1'b1;
      ld_total = rep_r;
      ld_eor   = 1'b1;
      rep_nxt  = '0;
      k_nxt    = '0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        top_nxt[s] = '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_REPORTS_RST;
      pos_r       <= '0;
      rep_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        top_r[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      pos_r <= pos_nxt;
      rep_r <= rep_nxt;
      k_r   <= k_nxt;
      top_r <= top_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      line_r   <= ld_line;
      is_rep_r <= ld_is_rep;
      total_r  <= ld_total;
      eor_r    <= ld_eor;
    end
  end

  // One stack memory per bracket class.
  for (genvar g = 0; g < NUM_STACKS; g++) begin : g_stack
    ubr_ram #(
      .WIDTH (POS_W),
      .DEPTH (DOC_LINES)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[g]),
      .wr_addr (tok_top[POS_W-1:0]),
      .wr_data (pos_r),
      .rd_en   (rd_en[g]),
      .rd_addr (k_r[POS_W-1:0]),
      .rd_data (rd_data[g])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_line      = line_r;
  assign out_is_report = is_rep_r;
  assign out_total     = total_r;
  assign out_eor       = eor_r;

endmodule

/* rtl/ubr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubr_ctrl: controller of the unbalanced bracket reporter
// Accepts tokens, walks the three stacks on the last token and issues the
// summary item.
// ----------------------------------------------------------------------------
module ubr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  ubr_pkg::ubr_sts_t sts,
  output ubr_pkg::ubr_cmd_t cmd
);
  import ubr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'b0001,
    ST_FLUSH_RD   = 4'b0010,
    ST_FLUSH_EMIT = 4'b0100,
    ST_SUMMARY    = 4'b1000
  } ubr_state_t;

  ubr_state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  assign in_ready = (state_r == ST_IDLE) && sts.out_free;

  // Sequencing of the scan and the flush walk.
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.stack_sel = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (in_last) begin
            state_nxt = ST_FLUSH_RD;
            sel_nxt   = STK_MATRIX;
          end
        end
      end
      ST_FLUSH_RD: begin
        if (sts.cap_hit) begin
          state_nxt = ST_SUMMARY;
        end else if (sts.stack_done) begin
          if (sel_r == STK_ATTRIB) begin
            state_nxt = ST_SUMMARY;
          end else begin
            cmd.next_stack = 1'b1;
            sel_nxt        = sel_r + 1'b1;
          end
        end else begin
          cmd.flush_rd = 1'b1;
          state_nxt    = ST_FLUSH_EMIT;
        end
      end
      ST_FLUSH_EMIT: begin
        if (sts.out_free) begin
          cmd.flush_emit = 1'b1;
          state_nxt      = ST_FLUSH_RD;
        end
      end
      ST_SUMMARY: begin
        if (sts.out_free) begin
          cmd.summary = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= STK_MATRIX;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

/* rtl/unbalanced_bracket_reporter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unbalanced_bracket_reporter: bracket-matching stack checker
// Numbers incoming command tokens, matches openers and closers on three
// stacks (matrix, begin, attribute), reports orphan closers at once and
// flushes unclosed openers with a summary item on the last token.
//
//   Channel   Direction  Handshake          Contents
//   in_chan   in         valid/ready        token_kind, token_valid, last_token
//   out_chan  out        valid/ready        line_index, is_report, report_total,
//                                           end_of_run
//   cfg_*     in         write enable only  max_reports
//
// Ordinary tokens are taken one per cycle while the result register is free or
// being drained.
// A last token starts the flush walk: each unclosed opener is read from its
// registered stack memory and then emitted, stack by stack, and the summary follows.
// Synchronous active-low reset clears control state; stack memories need no
// clearing pass, as every entry is written before it is read.
// A stalled result holds the block, and input is refused until it drains.
// ----------------------------------------------------------------------------
module unbalanced_bracket_reporter (
  input  logic                      clk,
  input  logic                      rst_n,
  ubr_tok_if.sink                   in_chan,
  ubr_res_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [ubr_pkg::REP_W-1:0] cfg_wdata
);
  import ubr_pkg::*;

  ubr_cmd_t cmd;
  ubr_sts_t sts;

  // Controller.
  ubr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last_token),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  ubr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_chan.token_kind),
    .in_tvalid     (in_chan.token_valid),
    .in_last       (in_chan.last_token),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_line      (out_chan.line_index),
    .out_is_report (out_chan.is_report),
    .out_total     (out_chan.report_total),
    .out_eor       (out_chan.end_of_run)
  );

endmodule

/* rtl/ubr_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubr_chk: port checker for the unbalanced bracket reporter
// Watches the top-level ports and flags results that break the scan rules.
// ----------------------------------------------------------------------------
module ubr_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ubr_pkg::LINE_W-1:0] line_index,
  input logic                      is_report,
  input logic [ubr_pkg::REP_W-1:0] report_total,
  input logic                      end_of_run
);
  import ubr_pkg::*;

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_index) &&
      $stable(is_report) && $stable(report_total) && $stable(end_of_run))
    else $error("result changed while stalled");

  // The summary item always closes the run.
  a_sum_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_report |-> end_of_run)
    else $error("summary item without end of run");

  // Report items carry no total.
  a_rep_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_report |-> report_total == '0)
    else $error("report item with non-zero total");

  // No token is taken while a run still has results to come.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !(out_valid && !end_of_run))
    else $error("token accepted during an unfinished run");

endmodule

bind unbalanced_bracket_reporter ubr_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .line_index   (out_chan.line_index),
  .is_report    (out_chan.is_report),
  .report_total (out_chan.report_total),
  .end_of_run   (out_chan.end_of_run)
);

/* tb/unbalanced_bracket_reporter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unbalanced_bracket_reporter_tb: self-checking bench for the bracket reporter
// Sends token requests through the input channel with random gaps and
// stalls the result channel at random. Every accepted token is run through
// a behavioural copy of the three opener stacks, and the report and summary
// requests it should cause are queued and compared field by field with what
// the block returns. A short directed table comes first. A scan then opens
// more begins than the report cap lets through. Random scans follow under
// several report caps, zero and the maximum among them.
// ----------------------------------------------------------------------------
module unbalanced_bracket_reporter_tb;
  import ubr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  // Cycles allowed for the block to settle once the last result is in.
  localparam int SETTLE_CYCLES = 16;
  // The one kind code that the package leaves unnamed; it counts as other.
  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              is_rep;
    logic [REP_W-1:0]  total;
    logic              eor;
  } bracket_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              tv;
    logic              last;
    logic              typed;
    bracket_result_t   want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [REP_W-1:0] cfg_wdata;

  ubr_tok_if tok_ch ();
  ubr_res_if res_ch ();

  unbalanced_bracket_reporter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (tok_ch),
    .out_chan  (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Behavioural copy of the block's state.
  logic [POS_W-1:0] open_pos [NUM_STACKS][DOC_LINES];
  int               open_depth [NUM_STACKS];
  logic [POS_W-1:0] cur_pos;
  int               reports_made;
  logic [REP_W-1:0] report_cap;

  bracket_result_t awaited_results [$];
  bracket_result_t fresh_results [$];

  int error_count;
  int cycle_count;
  int sink_hold;
  bit quiet_run;

  // Directed table. Rows with typed set carry their single expected result.
  stim_row_t directed_rows [0:18] = '{
    '{KIND_POP_MATRIX,  1'b1, 1'b0, 1'b1, '{10'd0,  1'b1, 6'd0, 1'b1}},
    '{KIND_POP_ATTRIB,  1'b0, 1'b0, 1'b0, '0},
    '{KIND_SPARE,       1'b1, 1'b0, 1'b0, '0},
    '{KIND_OTHER,       1'b1, 1'b0, 1'b0, '0},
    '{KIND_PUSH_MATRIX, 1'b1, 1'b0, 1'b0, '0},
    '{KIND_BEGIN,       1'b1, 1'b0, 1'b0, '0},
    '{KIND_PUSH_ATTRIB, 1'b1, 1'b0, 1'b0, '0},
    '{KIND_END,         1'b1, 1'b0, 1'b0, '0},
    '{KIND_POP_ATTRIB,  1'b1, 1'b0, 1'b0, '0},
    '{KIND_END,         1'b1, 1'b0, 1'b1, '{10'd9,  1'b1, 6'd0, 1'b1}},
    '{KIND_POP_ATTRIB,  1'b1, 1'b0, 1'b1, '{10'd10, 1'b1, 6'd0, 1'b1}},
    '{KIND_BEGIN,       1'b0, 1'b0, 1'b0, '0},
    '{KIND_BEGIN,       1'b1, 1'b0, 1'b0, '0},
    '{KIND_PUSH_ATTRIB, 1'b1, 1'b0, 1'b0, '0},
    '{KIND_PUSH_MATRIX, 1'b1, 1'b1, 1'b0, '0},
    '{KIND_POP_MATRIX,  1'b1, 1'b1, 1'b0, '0},
    '{KIND_OTHER,       1'b1, 1'b1, 1'b1, '{10'd0,  1'b0, 6'd0, 1'b1}},
    '{KIND_SPARE,       1'b0, 1'b1, 1'b1, '{10'd0,  1'b0, 6'd0, 1'b1}},
    '{KIND_PUSH_ATTRIB, 1'b0, 1'b1, 1'b1, '{10'd0,  1'b0, 6'd0, 1'b1}}
  };

  // Clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [KIND_W-1:0] opener_kind(input int s);
    case (s)
      int'(STK_MATRIX): return KIND_PUSH_MATRIX;
      int'(STK_BEGIN):  return KIND_BEGIN;
      default:          return KIND_PUSH_ATTRIB;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] closer_kind(input int s);
    case (s)
      int'(STK_MATRIX): return KIND_POP_MATRIX;
      int'(STK_BEGIN):  return KIND_END;
      default:          return KIND_POP_ATTRIB;
    endcase
  endfunction

  // Adds a report unless the cap for this scan has been reached.
  function automatic void note_report(input logic [POS_W-1:0] pos);
    if (reports_made < int'(report_cap)) begin
      fresh_results.push_back('{pos, 1'b1, '0, 1'b0});
      reports_made++;
    end
  endfunction

  // Works out the results one accepted token causes and updates the state.
  function automatic void predict_token(input logic [KIND_W-1:0] kind,
                                        input logic tv, input logic last);
    int  s;
    int  k;
    bit  opener;
    bit  closer;
    opener = 1'b0;
    closer = 1'b0;
    s = int'(STK_MATRIX);
    fresh_results.delete();
    if (tv) begin
      case (kind)
        KIND_PUSH_MATRIX: begin s = int'(STK_MATRIX); opener = 1'b1; end
        KIND_POP_MATRIX:  begin s = int'(STK_MATRIX); closer = 1'b1; end
        KIND_BEGIN:       begin s = int'(STK_BEGIN);  opener = 1'b1; end
        KIND_END:         begin s = int'(STK_BEGIN);  closer = 1'b1; end
        KIND_PUSH_ATTRIB: begin s = int'(STK_ATTRIB); opener = 1'b1; end
        KIND_POP_ATTRIB:  begin s = int'(STK_ATTRIB); closer = 1'b1; end
        default: ;
      endcase
    end
    // A push onto a full stack is dropped; a pop of an empty one is an orphan.
    if (opener && open_depth[s] < DOC_LINES) begin
      open_pos[s][open_depth[s]] = cur_pos;
      open_depth[s]++;
    end else if (closer) begin
      if (open_depth[s] > 0)
        open_depth[s]--;
      else
        note_report(cur_pos);
    end
    // The last token flushes every stack bottom-up, then sums up the scan.
    if (last) begin
      for (s = 0; s < NUM_STACKS; s++) begin
        for (k = 0; k < open_depth[s]; k++)
          note_report(open_pos[s][k]);
        open_depth[s] = 0;
      end
      fresh_results.push_back('{'0, 1'b0, reports_made[REP_W-1:0], 1'b0});
      reports_made = 0;
      cur_pos = '0;
    end else if (int'(cur_pos) == DOC_LINES - 1) begin
      cur_pos = '0;
    end else begin
      cur_pos = cur_pos + 1'b1;
    end
    if (fresh_results.size() > 0)
      fresh_results[fresh_results.size() - 1].eor = 1'b1;
  endfunction

  // Offers one token request, at times after a random gap, and waits for it to go.
  task automatic send_token(input logic [KIND_W-1:0] kind, input logic tv,
                            input logic last, input logic typed,
                            input bracket_result_t want);
    if (!quiet_run && $urandom_range(0, 5) == 0) begin
      tok_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    tok_ch.valid       <= 1'b1;
    tok_ch.token_kind  <= kind;
    tok_ch.token_valid <= tv;
    tok_ch.last_token  <= last;
    @(posedge clk);
    while (tok_ch.ready !== 1'b1) @(posedge clk);
    predict_token(kind, tv, last);
    if (typed)
      awaited_results.push_back(want);
    else
      foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
  endtask

  // Holds the sender back until every awaited result has come.
  task automatic pause_for_results();
    tok_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_cap(input logic [REP_W-1:0] value);
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    report_cap = value;
  endtask

  // Picks a stack that has an opener to close, now and then any stack.
  function automatic int pick_close_stack();
    int open_list [$];
    int s;
    for (s = 0; s < NUM_STACKS; s++)
      if (open_depth[s] > 0) open_list.push_back(s);
    if (open_list.size() == 0 || $urandom_range(0, 7) == 0)
      return $urandom_range(0, NUM_STACKS - 1);
    return open_list[$urandom_range(0, open_list.size() - 1)];
  endfunction

  // One stretch of tokens. A tidy stretch mostly opens and closes brackets;
  // an untidy one is raw noise, which may end scans of its own accord.
  task automatic run_scan(input int len, input bit tidy, input bit close);
    int                i;
    int                pick;
    logic [KIND_W-1:0] kind;
    logic              tv;
    logic              last;
    for (i = 0; i < len; i++) begin
      last = close && (i == len - 1);
      if (tidy) begin
        pick = $urandom_range(0, 9);
        tv   = ($urandom_range(0, 15) != 0);
        if (pick < 4)
          kind = opener_kind($urandom_range(0, NUM_STACKS - 1));
        else if (pick < 8)
          kind = closer_kind(pick_close_stack());
        else
          kind = (pick == 8) ? KIND_OTHER : KIND_SPARE;
      end else begin
        kind = KIND_W'($urandom_range(0, 7));
        tv   = 1'($urandom_range(0, 1));
        last = last || ($urandom_range(0, 11) == 0);
      end
      send_token(kind, tv, last, 1'b0, '0);
    end
  endtask

  // Random scans under one cap until the budget of tokens is spent.
  task automatic run_phase(input logic [REP_W-1:0] cap, input int budget);
    int sent;
    int len;
    set_cap(cap);
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 110)
                                        : $urandom_range(1, 24);
      if (len > budget - sent)
        len = budget - sent;
      run_scan(len, $urandom_range(0, 3) != 0, 1'b1);
      sent += len;
    end
  endtask

  // One scan that opens more begins than the cap lets through.
  task automatic overflow_scan();
    int i;
    for (i = 0; i < 70; i++)
      send_token(KIND_BEGIN, 1'b1, 1'b0, 1'b0, '0);
    send_token(KIND_PUSH_ATTRIB, 1'b1, 1'b1, 1'b0, '0);
  endtask

  // Result side: random stall bursts, none in the closing part of the run.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      res_ch.ready <= 1'b0;
    end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(1, 14) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compares each accepted result request with the oldest expectation.
  always @(posedge clk) begin : result_check
    bracket_result_t got;
    bracket_result_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = '{res_ch.line_index, res_ch.is_report, res_ch.report_total,
              res_ch.end_of_run};
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing awaited, line %0d", got.line));
      end else begin
        want = awaited_results.pop_front();
        if (got.line !== want.line)
          flag_mismatch($sformatf("line_index %0d, wanted %0d", got.line, want.line));
        if (got.is_rep !== want.is_rep)
          flag_mismatch($sformatf("is_report %0b, wanted %0b", got.is_rep, want.is_rep));
        if (got.total !== want.total)
          flag_mismatch($sformatf("report_total %0d, wanted %0d", got.total, want.total));
        if (got.eor !== want.eor)
          flag_mismatch($sformatf("end_of_run %0b, wanted %0b", got.eor, want.eor));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results still awaited", awaited_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    error_count  = 0;
    cycle_count  = 0;
    sink_hold    = 0;
    quiet_run    = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    tok_ch.valid       = 1'b0;
    tok_ch.token_kind  = KIND_OTHER;
    tok_ch.token_valid = 1'b0;
    tok_ch.last_token  = 1'b0;
    res_ch.ready       = 1'b0;
    for (r = 0; r < NUM_STACKS; r++) open_depth[r] = 0;
    cur_pos      = '0;
    reports_made = 0;
    report_cap   = MAX_REPORTS_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the cap left by reset.
    for (r = 0; r < $size(directed_rows); r++)
      send_token(directed_rows[r].kind, directed_rows[r].tv, directed_rows[r].last,
                 directed_rows[r].typed, directed_rows[r].want);

    overflow_scan();

    // Random scans over a spread of caps, the extremes among them.
    run_phase(6'd0, 20);
    run_phase(6'd1, 30);
    run_phase(REP_W'($urandom_range(2, 10)), 40);
    set_cap(6'd63);
    run_scan(10, 1'b1, 1'b0);
    pause_for_results();
    run_scan(10, 1'b1, 1'b1);
    run_phase(6'd63, 30);
    run_phase(REP_W'($urandom_range(1, 62)), 40);
    quiet_run = 1'b1;
    run_phase(REP_W'($urandom_range(3, 63)), 40);

    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/ubr_pkg.sv
rtl/ubr_if.sv
rtl/ubr_ram.sv
rtl/ubr_dp.sv
rtl/ubr_ctrl.sv
rtl/unbalanced_bracket_reporter.sv
rtl/ubr_chk.sv
tb/unbalanced_bracket_reporter_tb.sv
